### rtl/cles_pkg.sv
// Shared types, codes and constants for the character LCD expander sequencer.
package cles_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int WAIT_W     = 20;
	localparam int STEP_W     = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TALL_FONT  = 2'd1;

	typedef enum logic [3:0] {
		ACT_INIT       = 4'd0,
		ACT_CLEAR      = 4'd1,
		ACT_HOME       = 4'd2,
		ACT_DISPLAY    = 4'd3,
		ACT_CURSOR     = 4'd4,
		ACT_BLINK      = 4'd5,
		ACT_SCROLL     = 4'd6,
		ACT_DIRECTION  = 4'd7,
		ACT_AUTOSCROLL = 4'd8,
		ACT_SET_CURSOR = 4'd9,
		ACT_CHAR       = 4'd10,
		ACT_GLYPH      = 4'd11,
		ACT_BACKLIGHT  = 4'd12
	} action_t;

	// What the back end does with one queue entry
	typedef enum logic [1:0] {
		KIND_SEND  = 2'd0,
		KIND_INIT  = 2'd1,
		KIND_LIGHT = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;        // command/data byte; function byte for init
		logic       rs;          // register select
		logic       long_settle; // clear/home settle time after the last nibble
		logic       bl;          // backlight bit for every byte of the run
	} q_entry_t;

	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_HOME     = 8'h02;
	localparam logic [7:0] CMD_ENTRY    = 8'h04;
	localparam logic [7:0] CMD_DISPLAY  = 8'h08;
	localparam logic [7:0] CMD_SHIFT    = 8'h18;
	localparam logic [7:0] CMD_SHIFT_R  = 8'h04;
	localparam logic [7:0] CMD_FUNCTION = 8'h20;
	localparam logic [7:0] CMD_CGRAM    = 8'h40;
	localparam logic [7:0] CMD_DDRAM    = 8'h80;

	localparam logic [2:0] DISP_ON    = 3'h4;
	localparam logic [2:0] DISP_CURS  = 3'h2;
	localparam logic [2:0] DISP_BLINK = 3'h1;
	localparam logic [1:0] ENTRY_LTR  = 2'h2;
	localparam logic [1:0] ENTRY_AUTO = 2'h1;

	localparam logic [WAIT_W-1:0] WAIT_NONE     = 20'd0;
	localparam logic [WAIT_W-1:0] WAIT_ENABLE   = 20'd1;
	localparam logic [WAIT_W-1:0] WAIT_LATCH    = 20'd50;
	localparam logic [WAIT_W-1:0] WAIT_LONG     = 20'd2050;
	localparam logic [WAIT_W-1:0] WAIT_WAKE     = 20'd4550;
	localparam logic [WAIT_W-1:0] WAIT_WAKE_3   = 20'd200;
	localparam logic [WAIT_W-1:0] WAIT_POWER_UP = 20'd1000000;

	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		unique case (r)
			2'd0: b = 8'h00;
			2'd1: b = 8'h40;
			2'd2: b = 8'h14;
			default: b = 8'h54;
		endcase
		return b;
	endfunction

endpackage

### rtl/cles_front.sv
// Front end: takes operations, keeps the panel flags and queues one entry per known operation.
module cles_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [3:0]                     action,
	input  logic [7:0]                     value,
	input  logic [1:0]                     row,
	input  logic                           flag,
	input  logic                           cfg_valid,
	input  logic [cles_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cles_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           push_valid,
	input  logic                           push_ready,
	output cles_pkg::q_entry_t             push_entry
);
	import cles_pkg::*;

	logic [2:0] line_count_q;
	logic       tall_font_q;
	logic [2:0] display_flags_q;
	logic [1:0] entry_flags_q;
	logic [1:0] function_flags_q;
	logic       backlight_q;

	logic       accept;
	logic [2:0] disp_mask, disp_next;
	logic [1:0] entry_mask, entry_next;
	logic [1:0] func_next;
	logic [1:0] row_eff;
	logic [7:0] ddram_addr;
	logic       known;

	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;

	always_comb begin
		unique case (action)
			ACT_DISPLAY: disp_mask = DISP_ON;
			ACT_CURSOR:  disp_mask = DISP_CURS;
			default:     disp_mask = DISP_BLINK;
		endcase
		disp_next = flag ? (display_flags_q | disp_mask) : (display_flags_q & ~disp_mask);

		entry_mask = (action == ACT_DIRECTION) ? ENTRY_LTR : ENTRY_AUTO;
		entry_next = flag ? (entry_flags_q | entry_mask) : (entry_flags_q & ~entry_mask);

		func_next = function_flags_q
			| {line_count_q > 3'd1, tall_font_q && (line_count_q == 3'd1)};

		// clamp the row to the last line
		if ({1'b0, row} >= line_count_q)
			row_eff = (line_count_q == 3'd0) ? 2'd0 : 2'(line_count_q - 3'd1);
		else
			row_eff = row;
		ddram_addr = value + row_base(row_eff);
	end

	always_comb begin
		known                  = 1'b1;
		push_entry.kind        = KIND_SEND;
		push_entry.data        = 8'h00;
		push_entry.rs          = 1'b0;
		push_entry.long_settle = 1'b0;
		push_entry.bl          = backlight_q;
		unique case (action)
			ACT_INIT: begin
				push_entry.kind = KIND_INIT;
				push_entry.data = CMD_FUNCTION | {4'h0, func_next, 2'b00};
			end
			ACT_CLEAR: begin
				push_entry.data        = CMD_CLEAR;
				push_entry.long_settle = 1'b1;
			end
			ACT_HOME: begin
				push_entry.data        = CMD_HOME;
				push_entry.long_settle = 1'b1;
			end
			ACT_DISPLAY, ACT_CURSOR, ACT_BLINK: begin
				push_entry.data = CMD_DISPLAY | {5'h00, disp_next};
			end
			ACT_SCROLL: begin
				push_entry.data = flag ? (CMD_SHIFT | CMD_SHIFT_R) : CMD_SHIFT;
			end
			ACT_DIRECTION, ACT_AUTOSCROLL: begin
				push_entry.data = CMD_ENTRY | {6'h00, entry_next};
			end
			ACT_SET_CURSOR: begin
				push_entry.data = CMD_DDRAM | ddram_addr;
			end
			ACT_CHAR: begin
				push_entry.data = value;
				push_entry.rs   = 1'b1;
			end
			ACT_GLYPH: begin
				push_entry.data = CMD_CGRAM | {2'b00, value[2:0], 3'b000};
			end
			ACT_BACKLIGHT: begin
				push_entry.kind = KIND_LIGHT;
				push_entry.bl   = flag;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// unknown actions are taken and dropped
	assign push_valid = in_valid && known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q     <= 3'd2;
			tall_font_q      <= 1'b0;
			display_flags_q  <= 3'h0;
			entry_flags_q    <= 2'h0;
			function_flags_q <= 2'h0;
			backlight_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_LINE_COUNT)
					line_count_q <= cfg_data[2:0];
				else if (cfg_index == CFG_TALL_FONT)
					tall_font_q <= cfg_data[0];
			end
			if (accept) begin
				unique case (action)
					ACT_INIT: begin
						function_flags_q <= func_next;
						display_flags_q  <= DISP_ON;
						entry_flags_q    <= ENTRY_LTR;
					end
					ACT_DISPLAY, ACT_CURSOR, ACT_BLINK: display_flags_q <= disp_next;
					ACT_DIRECTION, ACT_AUTOSCROLL:      entry_flags_q   <= entry_next;
					ACT_BACKLIGHT:                      backlight_q     <= flag;
					default: ;
				endcase
			end
		end
	end

endmodule

### rtl/cles_queue.sv
// Short register queue between the front and back ends.
module cles_queue #(
	parameter int Depth = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  cles_pkg::q_entry_t push_entry,
	output logic               pop_valid,
	input  logic               pop_ready,
	output cles_pkg::q_entry_t pop_entry
);
	import cles_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	q_entry_t            mem [Depth];
	logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                push, pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### rtl/cles_back.sv
// Back end: expands each queue entry into expander bytes in an output register, one per cycle unless out_ready stalls.
module cles_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  cles_pkg::q_entry_t            pop_entry,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_byte,
	output logic [cles_pkg::WAIT_W-1:0]   out_wait,
	output logic                          out_last
);
	import cles_pkg::*;

	localparam logic [STEP_W-1:0] STEP_POWER  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_WAKE_3 = 4'd3;
	localparam logic [STEP_W-1:0] STEP_MODE4  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_FUNC   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_DISP   = 4'd6;
	localparam logic [STEP_W-1:0] STEP_CLEAR  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_ENTRY  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_LAST   = 4'd9;

	q_entry_t          cur_q;
	logic              cur_valid_q;
	logic [STEP_W-1:0] step_q;
	logic              half_q;
	logic [1:0]        phase_q;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [WAIT_W-1:0] out_wait_q;
	logic              out_last_q;

	logic              single_byte, single_nib, final_nib, op_end, item_last;
	logic [7:0]        cmd_byte, gen_byte;
	logic [3:0]        nib;
	logic              rs;
	logic [WAIT_W-1:0] final_wait, gen_wait;
	logic              slot_free, fire, load;

	always_comb begin
		single_byte = 1'b0;
		single_nib  = 1'b0;
		cmd_byte    = cur_q.data;
		rs          = cur_q.rs;
		final_wait  = cur_q.long_settle ? WAIT_LONG : WAIT_LATCH;
		unique case (cur_q.kind)
			KIND_SEND: ;
			KIND_LIGHT: single_byte = 1'b1;
			KIND_INIT: begin
				rs = 1'b0;
				if (step_q == STEP_POWER) begin
					single_byte = 1'b1;
				end else if (step_q < STEP_FUNC) begin
					// wake-up sequence: lone high nibbles
					single_nib = 1'b1;
					cmd_byte   = (step_q == STEP_MODE4) ? CMD_FUNCTION : 8'h30;
					if (step_q == STEP_MODE4)
						final_wait = WAIT_LATCH;
					else if (step_q == STEP_WAKE_3)
						final_wait = WAIT_WAKE_3;
					else
						final_wait = WAIT_WAKE;
				end else begin
					unique case (step_q)
						STEP_DISP:  cmd_byte = CMD_DISPLAY | {5'h00, DISP_ON};
						STEP_CLEAR: cmd_byte = CMD_CLEAR;
						STEP_ENTRY: cmd_byte = CMD_ENTRY | {6'h00, ENTRY_LTR};
						STEP_LAST:  cmd_byte = CMD_HOME;
						default:    cmd_byte = cur_q.data;
					endcase
					final_wait = (step_q == STEP_CLEAR || step_q == STEP_LAST)
						? WAIT_LONG : WAIT_LATCH;
				end
			end
			default: single_byte = 1'b1;
		endcase

		final_nib = single_nib || half_q;
		nib       = (half_q && !single_nib) ? cmd_byte[3:0] : cmd_byte[7:4];

		if (single_byte) begin
			gen_byte = {4'h0, cur_q.bl, 3'b000};
			gen_wait = (cur_q.kind == KIND_INIT) ? WAIT_POWER_UP : WAIT_NONE;
		end else begin
			gen_byte = {nib, cur_q.bl, phase_q == 2'd1, 1'b0, rs};
			unique case (phase_q)
				2'd0:    gen_wait = WAIT_NONE;
				2'd1:    gen_wait = WAIT_ENABLE;
				default: gen_wait = final_nib ? final_wait : WAIT_LATCH;
			endcase
		end

		op_end    = single_byte || (phase_q == 2'd2 && final_nib);
		item_last = op_end && (cur_q.kind != KIND_INIT || step_q == STEP_LAST);
	end

	assign slot_free = !out_valid_q || out_ready;
	assign fire      = cur_valid_q && slot_free;
	assign load      = pop_valid && (!cur_valid_q || (fire && item_last));
	assign pop_ready = !cur_valid_q || (fire && item_last);

	always_ff @(posedge clk) begin
		if (load)
			cur_q <= pop_entry;
		if (fire) begin
			out_byte_q <= gen_byte;
			out_wait_q <= gen_wait;
			out_last_q <= item_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= '0;
			half_q      <= 1'b0;
			phase_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (slot_free)
				out_valid_q <= fire;
			if (load) begin
				cur_valid_q <= 1'b1;
				step_q      <= '0;
				half_q      <= 1'b0;
				phase_q     <= 2'd0;
			end else if (fire) begin
				if (item_last) begin
					cur_valid_q <= 1'b0;
				end else if (op_end) begin
					// advance to the next init step
					step_q  <= step_q + 1'b1;
					half_q  <= 1'b0;
					phase_q <= 2'd0;
				end else if (phase_q == 2'd2) begin
					half_q  <= 1'b1;
					phase_q <= 2'd0;
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_wait  = out_wait_q;
	assign out_last  = out_last_q;

endmodule

### rtl/char_lcd_expander_sequencer_core.sv
// Top level of the character LCD expander sequencer.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tuser action, tdata value/row/flag
//  m_axis    out  tvalid/tready           tdata expander byte/wait, tlast end of run
//  cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// The back end sends one expander byte per cycle while m_axis is ready: a command or character
// is 6 bytes, backlight 1, init 43. The front end takes one operation per cycle while the queue
// has room, so the output byte rate sets the sustained throughput.
// Reset clears the queue, the output register and the panel flags; nothing to sweep.
// A stall on m_axis backs up into the queue and then s_axis; cfg is always ready.
module char_lcd_expander_sequencer_core #(
	parameter int QueueDepth = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [3:0]                      s_axis_tuser,  // action[3:0]
	input  logic [15:0]                     s_axis_tdata,  // value[7:0], row[9:8], flag[10]
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [31:0]                     m_axis_tdata,  // expander_byte[7:0], wait_us[27:8]
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cles_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cles_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cles_pkg::*;

	logic              push_valid, push_ready, pop_valid, pop_ready;
	q_entry_t          push_entry, pop_entry;
	logic [7:0]        out_byte;
	logic [WAIT_W-1:0] out_wait;

	assign cfg_ready = 1'b1;

	cles_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.action     (s_axis_tuser),
		.value      (s_axis_tdata[7:0]),
		.row        (s_axis_tdata[9:8]),
		.flag       (s_axis_tdata[10]),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	cles_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	cles_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (out_byte),
		.out_wait  (out_wait),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {4'h0, out_wait, out_byte};

endmodule

### rtl/cles_checker.sv
// Port-level checks for the sequencer core, bound to the top level.
module cles_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// hold a stalled beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	a_enable_wait: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[27:8] == 20'd1)
		else $error("enable-high byte without a one microsecond wait");

	a_last_enable_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[2])
		else $error("run ends on an enable-high byte");

	a_fixed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[1] && m_axis_tdata[31:28] == 4'h0)
		else $error("reserved output bits set");

	a_wait_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[27:8] <= 20'd1000000)
		else $error("wait beyond power-up delay");

endmodule

bind char_lcd_expander_sequencer_core cles_checker u_cles_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
